/* rtl/ble_pkg.sv */
`default_nettype none

package ble_pkg;

    localparam int KIND_W = 3;
    localparam int ELEM_W = 32;
    localparam int POS_W = 8;
    localparam int CNT_W = 7;

    localparam int DEF_CAPACITY = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND  = 3'd0,
        KIND_PREPEND = 3'd1,
        KIND_REMOVE  = 3'd2,
        KIND_INSERT  = 3'd3,
        KIND_REVERSE = 3'd4,
        KIND_READ    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_INS_RD,
        S_INS_WR,
        S_INS_FIN,
        S_REV_RA,
        S_REV_RB,
        S_REV_WA,
        S_REV_WB,
        S_RO_RD,
        S_RO_EMIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [ELEM_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic signed [ELEM_W-1:0] element;
        logic                     last;
        logic [CNT_W-1:0]         count;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_result;

endpackage

`default_nettype wire

/* rtl/ble_ram.sv */
`default_nettype none

module ble_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/ble_seq.sv */
`default_nettype none

module ble_seq
    import ble_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    localparam int SLOT_W = $clog2(CAPACITY)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire t_in_item               i_in_item,
    input  wire logic                   i_out_free,
    output t_result                     o_result,
    output logic                        o_wr_en,
    output logic [SLOT_W-1:0]           o_wr_addr,
    output logic [VALUE_WIDTH-1:0]      o_wr_data,
    output logic                        o_rd_en,
    output logic [SLOT_W-1:0]           o_rd_addr,
    input  wire logic [VALUE_WIDTH-1:0] i_rd_data
);

    localparam int SUM_W = CNT_W + 1;

    t_state                 r_state, n_state;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [SLOT_W-1:0]      r_front, n_front;
    logic [CNT_W-1:0]       r_i, n_i;
    logic [CNT_W-1:0]       r_j, n_j;
    logic [VALUE_WIDTH-1:0] r_tmp, n_tmp;
    t_status                r_status, n_status;
    logic                   full;
    logic                   ro_last;
    logic [SLOT_W-1:0]      prev_front;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] front,
                                                  input logic [CNT_W-1:0] idx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(idx);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[SLOT_W-1:0];
    endfunction

    assign full = (r_count >= CNT_W'(CAPACITY));
    assign ro_last = ((r_i + CNT_W'(1)) == r_count);
    assign prev_front = (r_front == '0) ? SLOT_W'(CAPACITY - 1) : r_front - SLOT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_front <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_front <= n_front;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_i      <= n_i;
        r_j      <= n_j;
        r_tmp    <= n_tmp;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_val    = r_val;
        n_pos    = r_pos;
        n_count  = r_count;
        n_front  = r_front;
        n_i      = r_i;
        n_j      = r_j;
        n_tmp    = r_tmp;
        n_status = r_status;
        o_in_ready = 1'b0;
        o_result   = '0;
        o_wr_en    = 1'b0;
        o_wr_addr  = '0;
        o_wr_data  = r_val;
        o_rd_en    = 1'b0;
        o_rd_addr  = '0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_kind  = i_in_item.kind;
                    n_val   = VALUE_WIDTH'($signed(i_in_item.value));
                    n_pos   = i_in_item.position;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_state  = S_RESP;
                case (r_kind)
                    KIND_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = slot_of(r_front, r_count);
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    KIND_PREPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = prev_front;
                            n_front   = prev_front;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    KIND_REMOVE: begin
                        if (r_count != '0) begin
                            n_front = (r_front == SLOT_W'(CAPACITY - 1)) ? '0
                                    : r_front + SLOT_W'(1);
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    KIND_INSERT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else if (r_pos > POS_W'(r_count)) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            n_i     = r_count;
                            n_state = (POS_W'(r_count) > r_pos) ? S_INS_RD : S_INS_FIN;
                        end
                    end
                    KIND_REVERSE: begin
                        if (r_count > CNT_W'(1)) begin
                            n_i     = '0;
                            n_j     = r_count - CNT_W'(1);
                            n_state = S_REV_RA;
                        end
                    end
                    KIND_READ: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_i     = '0;
                            n_state = S_RO_RD;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_INS_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = slot_of(r_front, r_i - CNT_W'(1));
                n_state   = S_INS_WR;
            end
            S_INS_WR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = slot_of(r_front, r_i);
                o_wr_data = i_rd_data;
                n_i       = r_i - CNT_W'(1);
                n_state   = (POS_W'(r_i - CNT_W'(1)) > r_pos) ? S_INS_RD : S_INS_FIN;
            end
            S_INS_FIN: begin
                o_wr_en   = 1'b1;
                o_wr_addr = slot_of(r_front, CNT_W'(r_pos));
                n_count   = r_count + CNT_W'(1);
                n_state   = S_RESP;
            end
            S_REV_RA: begin
                o_rd_en   = 1'b1;
                o_rd_addr = slot_of(r_front, r_i);
                n_state   = S_REV_RB;
            end
            S_REV_RB: begin
                o_rd_en   = 1'b1;
                o_rd_addr = slot_of(r_front, r_j);
                n_tmp     = i_rd_data;
                n_state   = S_REV_WA;
            end
            S_REV_WA: begin
                o_wr_en   = 1'b1;
                o_wr_addr = slot_of(r_front, r_i);
                o_wr_data = i_rd_data;
                n_state   = S_REV_WB;
            end
            S_REV_WB: begin
                o_wr_en   = 1'b1;
                o_wr_addr = slot_of(r_front, r_j);
                o_wr_data = r_tmp;
                n_i       = r_i + CNT_W'(1);
                n_j       = r_j - CNT_W'(1);
                n_state   = ((r_i + CNT_W'(2)) < r_j) ? S_REV_RA : S_RESP;
            end
            S_RO_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = slot_of(r_front, r_i);
                n_state   = S_RO_EMIT;
            end
            S_RO_EMIT: begin
                if (i_out_free) begin
                    o_result.valid        = 1'b1;
                    o_result.item.status  = ST_OK;
                    o_result.item.element = ELEM_W'($signed(i_rd_data));
                    o_result.item.last    = ro_last;
                    o_result.item.count   = r_count;
                    n_i     = r_i + CNT_W'(1);
                    n_state = ro_last ? S_IDLE : S_RO_RD;
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_result.valid        = 1'b1;
                    o_result.item.status  = r_status;
                    o_result.item.element = '0;
                    o_result.item.last    = 1'b1;
                    o_result.item.count   = r_count;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> i_out_free)
        else $error("result issued while output register is occupied");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_wr_en)
        else $error("store written with no transaction in progress");

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted transaction not executed");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_count <= CNT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

    a_readout_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (r_state == S_RO_EMIT)) |-> (r_count != '0))
        else $error("element read out of an empty list");

endmodule

`default_nettype wire

/* rtl/bounded_list_engine_core.sv */
// append, prepend, remove and refused inserts execute in S_EXEC, then answer from S_RESP
// insert: INS_RD, INS_WR per shifted entry, then INS_FIN; reverse: REV_RA/RB/WA/WB per pair
// read out: RO_RD then RO_EMIT per element, front first, RO_EMIT waits while output stalls
// one transaction in flight; the single-port-read store sets the per-step cost
// reset clears entry count and front slot, store contents stay undefined until written
`default_nettype none

module bounded_list_engine_core
    import ble_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int SLOT_W = $clog2(CAPACITY);

    logic                   r_out_valid;
    t_out_item              r_out_item;
    logic                   out_free;
    t_result                result;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    assign out_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_out_item <= result.item;
        end
    end

    ble_seq #(
        .CAPACITY   (CAPACITY),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item (i_in_item),
        .i_out_free(out_free),
        .o_result  (result),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    ble_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY),
        .ADDR_W(SLOT_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

endmodule

`default_nettype wire

/* tb/bounded_list_engine_checker.sv */
`default_nettype none

module bounded_list_engine_checker
    import ble_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_ready,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_ready,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_pending
);

    logic signed [ELEM_W-1:0] list_mem [CAPACITY];
    int                       list_len;
    int                       head_slot;
    t_out_item                pending_results [$];
    int                       fail_total = 0;

    function automatic int mem_index(input int idx);
        return (head_slot + idx) % CAPACITY;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_total++;
    endtask

    task automatic push_result(input t_status st, input logic signed [ELEM_W-1:0] elem,
                               input logic last);
        t_out_item r;
        r.status = st;
        r.element = elem;
        r.last = last;
        r.count = CNT_W'(list_len);
        pending_results.push_back(r);
    endtask

    task automatic apply_list_op(input t_in_item it);
        t_status                  st;
        logic signed [ELEM_W-1:0] tmp;
        int                       i;
        int                       j;
        bit                       full;
        st = ST_OK;
        full = (list_len >= CAPACITY);
        if (it.kind == KIND_READ) begin
            if (list_len == 0) begin
                push_result(ST_EMPTY, '0, 1'b1);
            end else begin
                for (i = 0; i < list_len; i++) begin
                    push_result(ST_OK, list_mem[mem_index(i)], i + 1 == list_len);
                end
            end
        end else begin
            case (it.kind)
                KIND_APPEND: begin
                    if (full) begin
                        st = ST_FULL;
                    end else begin
                        list_mem[mem_index(list_len)] = it.value;
                        list_len++;
                    end
                end
                KIND_PREPEND: begin
                    if (full) begin
                        st = ST_FULL;
                    end else begin
                        head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
                        list_mem[head_slot] = it.value;
                        list_len++;
                    end
                end
                KIND_REMOVE: begin
                    if (list_len > 0) begin
                        head_slot = (head_slot + 1) % CAPACITY;
                        list_len--;
                    end
                end
                KIND_INSERT: begin
                    // full is checked ahead of the position
                    if (full) begin
                        st = ST_FULL;
                    end else if (int'(it.position) > list_len) begin
                        st = ST_BAD_POS;
                    end else begin
                        for (i = list_len; i > int'(it.position); i--) begin
                            list_mem[mem_index(i)] = list_mem[mem_index(i - 1)];
                        end
                        list_mem[mem_index(int'(it.position))] = it.value;
                        list_len++;
                    end
                end
                KIND_REVERSE: begin
                    i = 0;
                    j = list_len - 1;
                    while (i < j) begin
                        tmp = list_mem[mem_index(i)];
                        list_mem[mem_index(i)] = list_mem[mem_index(j)];
                        list_mem[mem_index(j)] = tmp;
                        i++;
                        j--;
                    end
                end
                default: begin
                end
            endcase
            push_result(st, '0, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            list_len = 0;
            head_slot = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected transaction status %0d element %0d",
                                            i_out_item.status, i_out_item.element));
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_item.status !== want.status) begin
                        note_mismatch($sformatf("status got %0d want %0d",
                                                i_out_item.status, want.status));
                    end
                    if (i_out_item.element !== want.element) begin
                        note_mismatch($sformatf("element got %0d want %0d",
                                                i_out_item.element, want.element));
                    end
                    if (i_out_item.last !== want.last) begin
                        note_mismatch($sformatf("last got %0b want %0b",
                                                i_out_item.last, want.last));
                    end
                    if (i_out_item.count !== want.count) begin
                        note_mismatch($sformatf("count got %0d want %0d",
                                                i_out_item.count, want.count));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_list_op(i_in_item);
            end
        end
        o_pending <= pending_results.size();
        o_fail_count <= fail_total;
    end

endmodule

`default_nettype wire

/* tb/bounded_list_engine_core_tb.sv */
`default_nettype none

module bounded_list_engine_core_tb
    import ble_pkg::*;
;

    localparam int LIST_CAP = DEF_CAPACITY;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam logic [ELEM_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [ELEM_W-1:0] VAL_MAX = 32'h7fff_ffff;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_item = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    int fail_count;
    int pending_count;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    bounded_list_engine_core #(
        .CAPACITY(LIST_CAP),
        .VALUE_WIDTH(DEF_VALUE_WIDTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item)
    );

    bounded_list_engine_checker #(
        .CAPACITY(LIST_CAP)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_out_item(o_out_item),
        .o_fail_count(fail_count),
        .o_pending(pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic offer_item(input logic [KIND_W-1:0] kind, input logic [ELEM_W-1:0] value,
                              input logic [POS_W-1:0] pos);
        t_in_item it;
        it.kind = kind;
        it.value = value;
        it.position = pos;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 30);
            end
        end
    end

    initial begin
        int                  n;
        int                  phase;
        int                  roll;
        int                  t_app;
        int                  t_pre;
        int                  t_ins;
        int                  t_rem;
        int                  t_rev;
        int                  t_read;
        logic [KIND_W-1:0]   k;
        logic [ELEM_W-1:0]   v;
        logic [POS_W-1:0]    p;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases, single entry, bad positions, odd and even reverse
        offer_item(KIND_READ, '0, '0);
        offer_item(KIND_REMOVE, '0, '0);
        offer_item(KIND_REVERSE, '0, '0);
        offer_item(KIND_APPEND, VAL_MAX, '0);
        offer_item(KIND_REVERSE, '0, '0);
        offer_item(KIND_READ, '0, '0);
        offer_item(KIND_PREPEND, VAL_MIN, '0);
        offer_item(KIND_INSERT, 32'h1234_5678, 8'd3);
        offer_item(KIND_INSERT, 32'h1234_5678, 8'd255);
        offer_item(KIND_INSERT, 32'hffff_ffff, 8'd2);
        offer_item(KIND_INSERT, '0, 8'd0);
        offer_item(KIND_INSERT, 32'h5555_5555, 8'd1);
        offer_item(KIND_REVERSE, '0, '0);
        offer_item(KIND_READ, '0, '0);
        offer_item(KIND_SPARE_LO, 32'hdead_beef, 8'd7);
        offer_item(KIND_SPARE_HI, 32'hffff_ffff, 8'd255);
        offer_item(KIND_APPEND, 32'haaaa_aaaa, '0);
        offer_item(KIND_REVERSE, '0, '0);
        offer_item(KIND_READ, '0, '0);
        offer_item(KIND_REMOVE, '0, '0);
        offer_item(KIND_READ, '0, '0);

        for (n = 0; n < 400; n++) begin
            phase = (n / 50) % 3;
            calm = (n >= 200 && n < 280);
            if (n == 60) begin
                hold_req = 1'b1;
            end
            case (phase)
                0: begin
                    t_app = 30; t_pre = 50; t_ins = 75; t_rem = 80; t_rev = 87; t_read = 95;
                end
                1: begin
                    t_app = 8; t_pre = 14; t_ins = 20; t_rem = 80; t_rev = 87; t_read = 95;
                end
                default: begin
                    t_app = 17; t_pre = 34; t_ins = 50; t_rem = 70; t_rev = 82; t_read = 95;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < t_app) k = KIND_APPEND;
            else if (roll < t_pre) k = KIND_PREPEND;
            else if (roll < t_ins) k = KIND_INSERT;
            else if (roll < t_rem) k = KIND_REMOVE;
            else if (roll < t_rev) k = KIND_REVERSE;
            else if (roll < t_read) k = KIND_READ;
            else k = ($urandom_range(0, 1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;

            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end else begin
                v = $urandom();
            end
            if ($urandom_range(0, 9) == 0) p = POS_W'($urandom_range(0, 255));
            else p = POS_W'($urandom_range(0, LIST_CAP + 2));

            offer_item(k, v, p);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
